// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the solid face checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// File: hdl/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg
// Face tables, count codes and lane status type for the face decomposer.
// ---------------------------------------------------------------------------
package sfd_pkg;

  localparam int NUM_CORNERS = 8;
  localparam int NUM_FACES   = 6;
  localparam int NUM_TRIS    = 4;
  localparam int FACE_PTS    = 4;
  localparam int TRI_PTS     = 3;
  localparam int TUSER_W     = 7;

  // corner count codes
  localparam logic [2:0] CNT_NONE = 3'd0;
  localparam logic [2:0] CNT_TRI  = 3'd3;
  localparam logic [2:0] CNT_QUAD = 3'd4;

  // hexahedron faces as corner positions, slot order
  localparam logic [0:5][0:3][2:0] HEX_FACE = '{
    '{3'd0, 3'd3, 3'd2, 3'd1},
    '{3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd5, 3'd4},
    '{3'd2, 3'd3, 3'd7, 3'd6},
    '{3'd0, 3'd4, 3'd7, 3'd3},
    '{3'd1, 3'd2, 3'd6, 3'd5}
  };

  // tetrahedron triangles over distinct nodes in first-seen order
  localparam logic [0:3][0:2][1:0] TET_TRI = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd1, 2'd3},
    '{2'd0, 2'd2, 2'd3},
    '{2'd1, 2'd2, 2'd3}
  };

  typedef struct packed {
    logic       keep;   // three or four corners survive
    logic [2:0] count;  // corners left after dropping repeats
  } lane_stat_t;

endpackage

// File: hdl/sfd_face_lane.sv
// ---------------------------------------------------------------------------
// sfd_face_lane
// One face lane: drops repeated corners, keeps first-seen order, compacts.
// ---------------------------------------------------------------------------
module sfd_face_lane #(
  parameter int NODE_INDEX_BITS = 24
) (
  input  logic [3:0][NODE_INDEX_BITS-1:0] face_in,
  output logic [3:0][NODE_INDEX_BITS-1:0] face_out,
  output sfd_pkg::lane_stat_t             stat
);

  logic [3:0] fresh;
  logic [2:0] pos;

  always_comb begin
    fresh[0] = 1'b1;
    fresh[1] = face_in[1] != face_in[0];
    fresh[2] = (face_in[2] != face_in[0]) && (face_in[2] != face_in[1]);
    fresh[3] = (face_in[3] != face_in[0]) && (face_in[3] != face_in[1]) &&
               (face_in[3] != face_in[2]);
  end

  // compaction; unused slots stay zero
  always_comb begin
    face_out = '0;
    pos      = '0;
    for (int i = 0; i < sfd_pkg::FACE_PTS; i++) begin
      if (fresh[i]) begin
        face_out[pos[1:0]] = face_in[i];
        pos                = pos + 3'd1;
      end
    end
    stat.count = pos;
    stat.keep  = (pos == sfd_pkg::CNT_TRI) || (pos == sfd_pkg::CNT_QUAD);
  end

endmodule

// File: hdl/sfd_merge.sv
// ---------------------------------------------------------------------------
// sfd_merge
// Tetra check, face buffer of one element and result emitter (one per cycle unless stalled).
// ---------------------------------------------------------------------------
module sfd_merge #(
  parameter int NODE_INDEX_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [7:0][NODE_INDEX_BITS-1:0]       node,
  input  logic [5:0][3:0][NODE_INDEX_BITS-1:0]  lane_face,
  input  sfd_pkg::lane_stat_t [5:0]             lane_stat,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [3:0][NODE_INDEX_BITS-1:0]       out_corners,
  output logic [2:0]                            out_count,
  output logic [2:0]                            out_slot,
  output logic                                  out_tet,
  output logic                                  out_last
);

  localparam int NB = NODE_INDEX_BITS;

  logic                        tet;
  logic [5:0][3:0][NB-1:0]     ld_c;
  logic [5:0][2:0]             ld_n;
  logic [5:0]                  ld_mask;

  logic [5:0][3:0][NB-1:0]     ent_c_r;
  logic [5:0][2:0]             ent_n_r;
  logic                        ent_tet_r;
  logic [5:0]                  mask_r, mask_nxt;

  logic [2:0]                  pick;
  logic [5:0]                  rest;
  logic                        advance;
  logic                        accept;
  logic                        out_valid_r, out_valid_nxt;

  logic [3:0][NB-1:0]          out_c_r;
  logic [2:0]                  out_n_r;
  logic [2:0]                  out_slot_r;
  logic                        out_tet_r;
  logic                        out_last_r;

  // four distinct leading corners, upper corners all repeat corner 3
  always_comb begin
    tet = (node[0] != node[1]) && (node[0] != node[2]) && (node[0] != node[3]) &&
          (node[1] != node[2]) && (node[1] != node[3]) && (node[2] != node[3]) &&
          (node[4] == node[3]) && (node[5] == node[3]) &&
          (node[6] == node[3]) && (node[7] == node[3]);
  end

  always_comb begin
    ld_c    = '0;
    ld_n    = '0;
    ld_mask = '0;
    if (tet) begin
      for (int f = 0; f < sfd_pkg::NUM_TRIS; f++) begin
        for (int i = 0; i < sfd_pkg::TRI_PTS; i++) begin
          ld_c[f][i] = node[sfd_pkg::TET_TRI[f][i]];
        end
        ld_n[f]    = sfd_pkg::CNT_TRI;
        ld_mask[f] = 1'b1;
      end
    end else begin
      for (int f = 0; f < sfd_pkg::NUM_FACES; f++) begin
        if (lane_stat[f].keep) begin
          ld_c[f]    = lane_face[f];
          ld_n[f]    = lane_stat[f].count;
          ld_mask[f] = 1'b1;
        end
      end
      // nothing survived: slot 0 carries the empty marker (all zero)
      if (ld_mask == '0) begin
        ld_mask[0] = 1'b1;
      end
    end
  end

  // lowest pending slot goes next
  always_comb begin
    pick = '0;
    for (int f = sfd_pkg::NUM_FACES - 1; f >= 0; f--) begin
      if (mask_r[f]) begin
        pick = 3'(f);
      end
    end
    rest          = mask_r & ~(6'b000001 << pick);
    advance       = (mask_r != '0) && (!out_valid_r || out_ready);
    in_ready      = (mask_r == '0) || (advance && (rest == '0));
    accept        = in_valid && in_ready;
    out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    priority if (accept) begin
      mask_nxt = ld_mask;
    end else if (advance) begin
      mask_nxt = rest;
    end else begin
      mask_nxt = mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_c_r   <= ld_c;
      ent_n_r   <= ld_n;
      ent_tet_r <= tet;
    end
    if (advance) begin
      out_c_r    <= ent_c_r[pick];
      out_n_r    <= ent_n_r[pick];
      out_slot_r <= pick;
      out_tet_r  <= ent_tet_r;
      out_last_r <= (rest == '0);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_corners = out_c_r;
  assign out_count   = out_n_r;
  assign out_slot    = out_slot_r;
  assign out_tet     = out_tet_r;
  assign out_last    = out_last_r;

endmodule

// File: hdl/solid_face_decompose_unit.sv
// ---------------------------------------------------------------------------
// solid_face_decompose_unit
// Boundary faces of one possibly degenerate hexahedral solid per request.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: one request carries the eight corner node indices of a
//   solid. Output stream: one request per surviving face (triangle or quad),
//   tlast on the final face of the element; a solid with no surviving face
//   yields a single empty result (corner_count 0) with tlast set.
//   A tetrahedron (four distinct leading corners, corners 4..7 equal to
//   corner 3) yields four triangles flagged is_tetra.
//   Path: the face buffer loads when the input request is taken, and the
//   output register loads from the buffer once it is free.
//   Throughput: one result per cycle while out_tready is high; an element
//   has 1 to 6 results, and the next element is taken in the cycle its
//   last face moves into the output register, so back-to-back elements
//   leave with no gap. The rate is set by the single output register
//   draining the buffer. Stall: while out_tready is low the output
//   register and its payload hold; in_tready is high only while the
//   buffer is empty or its last queued face moves into the output register.
//   Reset (rst_n low, synchronous): buffer and output valid clear; no
//   clearing pass is needed.
// ---------------------------------------------------------------------------
module solid_face_decompose_unit #(
  parameter int NODE_INDEX_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata fields, low bit up: node_0 .. node_7, NODE_INDEX_BITS each
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [8*NODE_INDEX_BITS-1:0]     in_tdata,
  // out_tdata fields, low bit up: corner_a, corner_b, corner_c, corner_d,
  // zero padding to whole bytes
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [((4*NODE_INDEX_BITS+7)/8)*8-1:0] out_tdata,
  // out_tuser fields, low bit up: corner_count[2:0], face_slot[2:0], is_tetra
  output logic [sfd_pkg::TUSER_W-1:0]      out_tuser,
  output logic                             out_tlast
);

  localparam int NB    = NODE_INDEX_BITS;
  localparam int OUT_W = ((4*NB+7)/8)*8;

  logic [7:0][NB-1:0]          node;
  logic [5:0][3:0][NB-1:0]     lane_in;
  logic [5:0][3:0][NB-1:0]     lane_face;
  sfd_pkg::lane_stat_t [5:0]   lane_stat;
  logic [3:0][NB-1:0]          corners;
  logic [2:0]                  count;
  logic [2:0]                  slot;
  logic                        tet;

  assign node = in_tdata;

  // one dedup lane per hexahedron face, fed straight from the input bus
  for (genvar f = 0; f < sfd_pkg::NUM_FACES; f++) begin : g_lane
    for (genvar i = 0; i < sfd_pkg::FACE_PTS; i++) begin : g_pt
      assign lane_in[f][i] = node[sfd_pkg::HEX_FACE[f][i]];
    end
    sfd_face_lane #(
      .NODE_INDEX_BITS(NB)
    ) u_lane (
      .face_in (lane_in[f]),
      .face_out(lane_face[f]),
      .stat    (lane_stat[f])
    );
  end

  // tetra check, face buffer and emitter
  sfd_merge #(
    .NODE_INDEX_BITS(NB)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .node       (node),
    .lane_face  (lane_face),
    .lane_stat  (lane_stat),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_corners(corners),
    .out_count  (count),
    .out_slot   (slot),
    .out_tet    (tet),
    .out_last   (out_tlast)
  );

  assign out_tdata = OUT_W'(corners);
  assign out_tuser = {tet, slot, count};

endmodule

// File: hdl/sfd_checker.sv
// ---------------------------------------------------------------------------
// sfd_checker
// Port-level assertions for the solid face decomposer, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_checker #(
  parameter int NODE_INDEX_BITS = 24
) (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_tvalid,
  input logic                                    in_tready,
  input logic [8*NODE_INDEX_BITS-1:0]            in_tdata,
  input logic                                    out_tvalid,
  input logic                                    out_tready,
  input logic [((4*NODE_INDEX_BITS+7)/8)*8-1:0]  out_tdata,
  input logic [sfd_pkg::TUSER_W-1:0]             out_tuser,
  input logic                                    out_tlast
);

  logic [2:0] cnt;
  logic [2:0] slot;
  logic       tet;
  logic       in_seen;

  assign cnt     = out_tuser[2:0];
  assign slot    = out_tuser[5:3];
  assign tet     = out_tuser[6];
  assign in_seen = in_tvalid && in_tready && (in_tdata != '0 || in_tdata == '0);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // faces of one element leave without gaps
  `ASSERT_NEXT(a_no_gap, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid)

  // empty marker is always the sole, final result
  `ASSERT_IMPL(a_empty, clk, rst_n, out_tvalid && cnt == sfd_pkg::CNT_NONE, out_tlast && slot == 3'd0 && !tet)

  // tetrahedra are triangles ending on triangle three
  `ASSERT_IMPL(a_tet, clk, rst_n, out_tvalid && tet, cnt == sfd_pkg::CNT_TRI && (out_tlast == (slot == 3'd3)))

  // input is taken while a result is stalled only if that result is the element's last
  `ASSERT_IMPL(a_busy, clk, rst_n, in_seen && out_tvalid && !out_tready, out_tlast)

endmodule

bind solid_face_decompose_unit sfd_checker #(
  .NODE_INDEX_BITS(NODE_INDEX_BITS)
) u_sfd_checker (.*);
